// ----- rtl/core/dbwq_pkg.sv -----
// ----------------------------------------------------------------------------
// dbwq_pkg: shared types and constants of the distance bounded window queue
// Control word layout, the sequencer program, register indexes and the
// fixed field widths of the scan and result items.
// ----------------------------------------------------------------------------
package dbwq_pkg;

	// Fixed field widths.
	localparam int ID_W    = 16;
	localparam int POS_W   = 24;
	localparam int SEQ_W   = 32;
	localparam int CNT_W   = 5;
	localparam int LIM_W   = 50;
	localparam int SCAN_W  = ID_W + 2 * POS_W;
	localparam int OUT_W   = 56;

	// Results per scan, summary included, and the width of the eviction counter.
	localparam int MAX_RESULTS = 16;
	localparam int NRES_W      = $clog2(MAX_RESULTS);

	// Configuration register indexes and reset values.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DIST_LIMIT = CFG_IDX_W'(1);
	localparam logic [CNT_W-1:0] MAX_COUNT_RST  = CNT_W'(16);
	localparam logic [LIM_W-1:0] DIST_LIMIT_RST = {1'b0, {(LIM_W-1){1'b1}}};

	// Sequencer steps.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FULL_CHK,
		ST_EMIT_FULL,
		ST_STORE,
		ST_LOOP_CHK,
		ST_DIFF,
		ST_MULT,
		ST_CMP,
		ST_EMIT_EVICT,
		ST_EMIT_SUM
	} step_t;

	// Jump conditions.
	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_IN_VALID,
		COND_FULL,
		COND_LOOP,
		COND_EVICT
	} cond_t;

	// Result selection of a step.
	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_FULL,
		EMIT_EVICT,
		EMIT_SUMMARY
	} emit_t;

	// Controls of the distance unit.
	typedef struct packed {
		logic ld_diff;
		logic ld_sq;
	} dist_ctrl_t;

	// One control word.
	typedef struct packed {
		cond_t      cond;
		step_t      tgt_t;
		step_t      tgt_f;
		logic       store;
		dist_ctrl_t dist_ctl;
		emit_t      emit;
	} ucode_t;

	// The sequencer program. A step with a result waits for the output register.
	function automatic ucode_t ucode_rom(input step_t pc);
		ucode_t w;
		w.cond     = COND_ALWAYS;
		w.tgt_t    = ST_IDLE;
		w.tgt_f    = ST_IDLE;
		w.store    = 1'b0;
		w.dist_ctl = '0;
		w.emit     = EMIT_NONE;
		unique case (pc)
			ST_IDLE: begin
				w.cond  = COND_IN_VALID;
				w.tgt_t = ST_FULL_CHK;
				w.tgt_f = ST_IDLE;
			end
			ST_FULL_CHK: begin
				w.cond  = COND_FULL;
				w.tgt_t = ST_EMIT_FULL;
				w.tgt_f = ST_STORE;
			end
			ST_EMIT_FULL: begin
				w.tgt_t = ST_STORE;
				w.emit  = EMIT_FULL;
			end
			ST_STORE: begin
				w.tgt_t = ST_LOOP_CHK;
				w.store = 1'b1;
			end
			ST_LOOP_CHK: begin
				w.cond  = COND_LOOP;
				w.tgt_t = ST_DIFF;
				w.tgt_f = ST_EMIT_SUM;
			end
			ST_DIFF: begin
				w.tgt_t            = ST_MULT;
				w.dist_ctl.ld_diff = 1'b1;
			end
			ST_MULT: begin
				w.tgt_t          = ST_CMP;
				w.dist_ctl.ld_sq = 1'b1;
			end
			ST_CMP: begin
				w.cond  = COND_EVICT;
				w.tgt_t = ST_EMIT_EVICT;
				w.tgt_f = ST_EMIT_SUM;
			end
			ST_EMIT_EVICT: begin
				w.tgt_t = ST_LOOP_CHK;
				w.emit  = EMIT_EVICT;
			end
			ST_EMIT_SUM: begin
				w.tgt_t = ST_IDLE;
				w.emit  = EMIT_SUMMARY;
			end
			default: begin
				w.tgt_t = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/core/dbwq_ram.sv -----
// ----------------------------------------------------------------------------
// dbwq_ram: generic single write port, single read port RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dbwq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/dbwq_dist.sv -----
// ----------------------------------------------------------------------------
// dbwq_dist: squared distance unit
// Differences, squares and the threshold compare, one register between each.
// ----------------------------------------------------------------------------
module dbwq_dist (
	input  logic                                  clk,
	input  dbwq_pkg::dist_ctrl_t                  ctrl,
	input  logic signed [dbwq_pkg::POS_W-1:0]     front_x,
	input  logic signed [dbwq_pkg::POS_W-1:0]     front_y,
	input  logic signed [dbwq_pkg::POS_W-1:0]     new_x,
	input  logic signed [dbwq_pkg::POS_W-1:0]     new_y,
	input  logic signed [dbwq_pkg::LIM_W-1:0]     limit_sq,
	output logic                                  far
);
	import dbwq_pkg::*;

	localparam int DW  = POS_W + 1;
	localparam int PW  = 2 * DW;
	localparam int SQW = 2 * POS_W;
	localparam int SUMW = SQW + 1;
	localparam int CMPW = LIM_W + 1;

	logic signed [DW-1:0]  dx_q, dy_q;
	logic signed [PW-1:0]  px, py;
	logic [SQW-1:0]        sqx_q, sqy_q;
	logic [SUMW-1:0]       d2;

	// Differences between the front scan and the newest scan.
	always_ff @(posedge clk) begin
		if (ctrl.ld_diff) begin
			dx_q <= DW'(front_x) - DW'(new_x);
			dy_q <= DW'(front_y) - DW'(new_y);
		end
	end

	// Squares; each difference is below 2^24 in magnitude, so 48 bits hold them.
	assign px = dx_q * dx_q;
	assign py = dy_q * dy_q;

	always_ff @(posedge clk) begin
		if (ctrl.ld_sq) begin
			sqx_q <= px[SQW-1:0];
			sqy_q <= py[SQW-1:0];
		end
	end

	// Sum and signed compare against the threshold.
	assign d2  = {1'b0, sqx_q} + {1'b0, sqy_q};
	assign far = $signed({{(CMPW-SUMW){1'b0}}, d2}) > $signed({limit_sq[LIM_W-1], limit_sq});

endmodule

// ----- rtl/core/distance_bounded_window_queue_unit.sv -----
// ----------------------------------------------------------------------------
// distance_bounded_window_queue_unit: sliding scan window with eviction
// Appends each scan to a circular window and evicts from the front on count
// or squared distance, reporting each eviction and then one summary.
//
// Channel  Direction  Handshake          Payload
// s_*      in         s_tvalid/s_tready  s_tdata: scan_id, pos_x, pos_y
// m_*      out        m_tvalid/m_tready  m_tdata, m_tuser (kind), m_tlast
// cfg_*    in         cfg_valid/ready    cfg_index, cfg_data
//
// A scan takes a full check and the store, then for each eviction a distance
// check (difference, square, compare) and its result, then a last check that
// keeps the front, skipped once only the newest scan is left or the eviction
// cap is reached, and the summary. A full window first evicts its front. The
// step loop uses one memory read port and one pair of multipliers. One scan at
// a time. Reset clears the counters, index and valid flag and resets the
// limits, not the window. A stalled output holds the sequencer on its step.
// ----------------------------------------------------------------------------
module distance_bounded_window_queue_unit #(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Scan input.
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [dbwq_pkg::SCAN_W-1:0]           s_tdata,   // scan_id, pos_x, pos_y
	// Result output.
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [dbwq_pkg::OUT_W-1:0]            m_tdata,   // out_id, sequence_index,
	                                                         // window_count, zero pad
	output logic                                  m_tuser,   // kind
	output logic                                  m_tlast,
	// Configuration writes.
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [dbwq_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dbwq_pkg::LIM_W-1:0]            cfg_data
);
	import dbwq_pkg::*;

	localparam int AW  = $clog2(WINDOW_DEPTH);
	localparam int HW  = $clog2(WINDOW_DEPTH + 1);
	localparam int CW  = (HW > CNT_W) ? HW : CNT_W;
	localparam int X_LO = ID_W;
	localparam int Y_LO = ID_W + POS_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);

	// Sequencer and window state.
	step_t               pc_q;
	logic [HW-1:0]       held_q;
	logic [AW-1:0]       front_q;
	logic [NRES_W-1:0]   nres_q;
	logic [SEQ_W-1:0]    next_index_q;
	logic [CNT_W-1:0]    max_count_q;
	logic [LIM_W-1:0]    dist_limit_q;

	// Latched scan.
	logic [SCAN_W-1:0]   scan_q;
	logic [SEQ_W-1:0]    seq_q;

	// Output register.
	logic                out_valid_q;
	logic [ID_W-1:0]     out_id_q;
	logic [SEQ_W-1:0]    out_seq_q;
	logic [CNT_W-1:0]    out_cnt_q;
	logic                out_kind_q;
	logic                out_last_q;

	ucode_t              uw;
	logic                accept, slot_free, emit_go, stall, cond_hit, drop, far;
	logic [SCAN_W-1:0]   front_rd;
	logic [AW-1:0]       newest;
	logic [CW:0]         pos_sum;
	logic [CW-1:0]       held_c, limit_c, cnt_c;
	logic [ID_W-1:0]     emit_id;

	// Current control word and handshakes.
	assign uw        = ucode_rom(pc_q);
	assign s_tready  = (pc_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || m_tready;
	assign emit_go   = (uw.emit != EMIT_NONE) && slot_free;
	assign stall     = (uw.emit != EMIT_NONE) && !slot_free;
	assign drop      = emit_go && ((uw.emit == EMIT_FULL) || (uw.emit == EMIT_EVICT));

	// Count limit: zero means one, and it never exceeds the window depth.
	assign held_c = CW'(held_q);
	always_comb begin
		if (max_count_q == '0) begin
			limit_c = CW'(1);
		end else if (CW'(max_count_q) > DEPTH_C) begin
			limit_c = DEPTH_C;
		end else begin
			limit_c = CW'(max_count_q);
		end
	end

	// Slot of the newest scan; the sum stays below twice the depth.
	assign pos_sum = (CW + 1)'(front_q) + (CW + 1)'(held_q);
	assign newest  = (pos_sum >= (CW + 1)'(WINDOW_DEPTH)) ?
		AW'(pos_sum - (CW + 1)'(WINDOW_DEPTH)) : AW'(pos_sum);

	// Jump condition of the current step.
	always_comb begin
		unique case (uw.cond)
			COND_ALWAYS:   cond_hit = 1'b1;
			COND_IN_VALID: cond_hit = s_tvalid;
			COND_FULL:     cond_hit = (held_c >= DEPTH_C);
			COND_LOOP:     cond_hit = (held_q > HW'(1)) &&
			                          (nres_q < NRES_W'(MAX_RESULTS - 1));
			COND_EVICT:    cond_hit = (held_c > limit_c) || far;
			default:       cond_hit = 1'b0;
		endcase
	end

	// Result fields of an emitting step.
	always_comb begin
		unique case (uw.emit)
			EMIT_EVICT: begin
				emit_id = front_rd[ID_W-1:0];
				cnt_c   = held_c - CW'(1);
			end
			EMIT_SUMMARY: begin
				emit_id = scan_q[ID_W-1:0];
				cnt_c   = held_c;
			end
			default: begin
				emit_id = front_rd[ID_W-1:0];
				cnt_c   = held_c;
			end
		endcase
	end

	// Window storage: written at the newest slot, read at the front.
	dbwq_ram #(
		.WIDTH (SCAN_W),
		.DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (uw.store),
		.waddr (newest),
		.wdata (scan_q),
		.raddr (front_q),
		.rdata (front_rd)
	);

	// Squared distance from the front scan to the newest scan.
	dbwq_dist u_dist (
		.clk      (clk),
		.ctrl     (uw.dist_ctl),
		.front_x  (front_rd[X_LO +: POS_W]),
		.front_y  (front_rd[Y_LO +: POS_W]),
		.new_x    (scan_q[X_LO +: POS_W]),
		.new_y    (scan_q[Y_LO +: POS_W]),
		.limit_sq (dist_limit_q),
		.far      (far)
	);

	// Control state: step counter, window pointers, counters and registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q         <= ST_IDLE;
			held_q       <= '0;
			front_q      <= '0;
			nres_q       <= '0;
			next_index_q <= '0;
			max_count_q  <= MAX_COUNT_RST;
			dist_limit_q <= DIST_LIMIT_RST;
			out_valid_q  <= 1'b0;
		end else begin
			if (!stall) begin
				pc_q <= cond_hit ? uw.tgt_t : uw.tgt_f;
			end
			if (accept) begin
				next_index_q <= next_index_q + SEQ_W'(1);
				nres_q       <= '0;
			end
			if (drop) begin
				front_q <= (front_q == AW'(WINDOW_DEPTH - 1)) ? '0 : front_q + AW'(1);
				held_q  <= held_q - HW'(1);
				nres_q  <= nres_q + NRES_W'(1);
			end else if (uw.store) begin
				held_q <= held_q + HW'(1);
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_MAX_COUNT:  max_count_q  <= cfg_data[CNT_W-1:0];
					REG_DIST_LIMIT: dist_limit_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			scan_q <= s_tdata;
			seq_q  <= next_index_q;
		end
		if (emit_go) begin
			out_id_q   <= emit_id;
			out_seq_q  <= seq_q;
			out_cnt_q  <= cnt_c[CNT_W-1:0];
			out_kind_q <= (uw.emit == EMIT_SUMMARY);
			out_last_q <= (uw.emit == EMIT_SUMMARY);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W - ID_W - SEQ_W - CNT_W){1'b0}}, out_cnt_q, out_seq_q, out_id_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTH
	// The window never holds more scans than its depth.
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HW'(WINDOW_DEPTH))
		else $error("window count above depth");

	// Only the summary closes a scan, and only a summary is marked last.
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == m_tuser))
		else $error("last flag and summary kind disagree");

	// A summary always leaves the newest scan in the window.
	a_sum_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && (uw.emit == EMIT_SUMMARY)) |-> (held_q != '0))
		else $error("summary with an empty window");

	// An accepted scan blocks the input until its summary is written to the output register.
	a_one_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input taken while a scan is in work");
`endif

endmodule
